>>> sv/json_text_indenter_assert.svh
// ----------------------------------------------------------------------------
// json_text_indenter_assert.svh
// Assertion macros shared by the indenter checker
// ----------------------------------------------------------------------------
`ifndef JSON_TEXT_INDENTER_ASSERT_SVH
`define JSON_TEXT_INDENTER_ASSERT_SVH

// property checked only while out of reset
`define JTI_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("jti assertion failed");

// property checked at every edge, reset included
`define JTI_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("jti assertion failed");

`endif

>>> sv/jti_pkg.sv
// ----------------------------------------------------------------------------
// jti_pkg
// Character codes, widths and sequencer states of the JSON text indenter
// ----------------------------------------------------------------------------
package jti_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned DepthW = 4;

  localparam logic [ByteW-1:0] ChLBrace = 8'h7B;
  localparam logic [ByteW-1:0] ChRBrace = 8'h7D;
  localparam logic [ByteW-1:0] ChLBrack = 8'h5B;
  localparam logic [ByteW-1:0] ChRBrack = 8'h5D;
  localparam logic [ByteW-1:0] ChComma  = 8'h2C;
  localparam logic [ByteW-1:0] ChColon  = 8'h3A;
  localparam logic [ByteW-1:0] ChSpace  = 8'h20;
  localparam logic [ByteW-1:0] ChNl     = 8'h0A;

  // register index of the configuration port
  localparam int unsigned RegFormatEnable = 0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_CLASS,
    ST_PRE_NL,
    ST_PRE_SP,
    ST_CHAR,
    ST_POST_NL,
    ST_POST_SP,
    ST_FINISH
  } state_e;

endpackage

>>> sv/json_text_indenter.sv
// Path: an accepted byte is captured, loaded as a job in ST_START, classified in ST_CLASS and
//   sent on through the output register; the input is ready again only in ST_IDLE, which the
//   sequencer reaches via ST_FINISH after the last output byte of a step is registered.
// Throughput: one output byte per cycle from a single output register unless stalled; a request
//   waits for the last step to end; an indented byte costs up to 2 + INDENT_WIDTH*depth bytes.
// Reset (rst_ni low, asynchronous): formatting on, nothing held, depths zero, output empty.
// ----------------------------------------------------------------------------
// json_text_indenter
// Re-emits compact JSON text as is or, when formatting is on, with newlines and brace-depth indentation
// ----------------------------------------------------------------------------
module json_text_indenter #(
  parameter int unsigned MAX_DEPTH    = 15,
  parameter int unsigned INDENT_WIDTH = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // input stream
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] text_byte
  input  logic       s_axis_tlast_i,   // end_of_text
  // output stream
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [7:0] out_byte
  output logic       m_axis_tlast_o,   // run_last
  // configuration port
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned ByteW  = jti_pkg::ByteW;
  localparam int unsigned DepthW = jti_pkg::DepthW;
  localparam int unsigned SpcW   = DepthW + $clog2(INDENT_WIDTH + 1);

  // configuration and stream state
  logic              fmt_en_q;
  logic [ByteW-1:0]  held_byte_q;
  logic              held_valid_q;
  logic [ByteW-1:0]  before_q;
  logic [DepthW-1:0] brace_q, brace_d;
  logic [DepthW-1:0] bracket_q, bracket_d;

  // captured request
  logic [ByteW-1:0]  in_byte_q;
  logic              in_last_q;
  logic              mode_q;

  // current job: one text byte with its neighbors
  logic [ByteW-1:0]  job_c_q, job_prev_q, job_next_q;
  logic              job_new_q;
  logic              post_q, post_d;
  logic [SpcW-1:0]   cnt_q, cnt_d;

  jti_pkg::state_e   state_q, state_d, job_end_st;

  // output register
  logic              out_valid_q;
  logic [ByteW-1:0]  out_byte_q;
  logic              out_last_q;

  logic              in_acc, cfg_wr, slot_free, second_needed, final_job;
  logic              emit, emit_last, is_rbrace;
  logic [ByteW-1:0]  emit_byte;

  assign in_acc        = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free     = !out_valid_q || m_axis_tready_i;
  assign second_needed = !mode_q || in_last_q;
  assign final_job     = job_new_q || !second_needed;
  assign job_end_st    = (!job_new_q && second_needed) ? jti_pkg::ST_CLASS
                                                       : jti_pkg::ST_FINISH;
  assign is_rbrace     = (job_c_q == jti_pkg::ChRBrace);

  assign s_axis_tready_o = (state_q == jti_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_byte_q;
  assign m_axis_tlast_o  = out_last_q;

  // configuration port
  assign pready_o = 1'b1;
  assign cfg_wr   = psel_i && penable_i && pwrite_i &&
                    (paddr_i == 3'(4 * jti_pkg::RegFormatEnable));
  assign prdata_o = (paddr_i == 3'(4 * jti_pkg::RegFormatEnable)) ?
                    {31'b0, fmt_en_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_en_q <= 1'b1;
    end else if (cfg_wr) begin
      fmt_en_q <= pwdata_i[0];
    end
  end

  // classifier: depth update and indent decision for the current job
  always_comb begin
    logic comma_ind, lbrack_ind;
    brace_d   = brace_q;
    bracket_d = bracket_q;
    if (job_c_q == jti_pkg::ChLBrace && brace_q < DepthW'(MAX_DEPTH)) begin
      brace_d = brace_q + 1'b1;
    end
    if (job_c_q == jti_pkg::ChRBrace && brace_q != '0) begin
      brace_d = brace_q - 1'b1;
    end
    if (job_c_q == jti_pkg::ChLBrack && bracket_q < DepthW'(MAX_DEPTH)) begin
      bracket_d = bracket_q + 1'b1;
    end
    if (job_c_q == jti_pkg::ChRBrack && bracket_q != '0) begin
      bracket_d = bracket_q - 1'b1;
    end
    comma_ind  = (job_c_q == jti_pkg::ChComma) &&
                 ((bracket_d == '0) ||
                  (bracket_d == DepthW'(1) && job_prev_q == jti_pkg::ChRBrack));
    lbrack_ind = (job_c_q == jti_pkg::ChLBrack) &&
                 (job_prev_q == jti_pkg::ChColon) &&
                 (job_next_q == jti_pkg::ChLBrack);
    post_d = mode_q && (comma_ind || lbrack_ind || job_c_q == jti_pkg::ChLBrace);
    cnt_d  = SpcW'(brace_d) * SpcW'(INDENT_WIDTH);
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      jti_pkg::ST_IDLE: begin
        if (in_acc) state_d = jti_pkg::ST_START;
      end
      jti_pkg::ST_START: begin
        state_d = (held_valid_q || second_needed) ? jti_pkg::ST_CLASS
                                                  : jti_pkg::ST_FINISH;
      end
      jti_pkg::ST_CLASS: begin
        state_d = (mode_q && is_rbrace) ? jti_pkg::ST_PRE_NL : jti_pkg::ST_CHAR;
      end
      jti_pkg::ST_PRE_NL: begin
        if (slot_free) begin
          state_d = (cnt_q != '0) ? jti_pkg::ST_PRE_SP : jti_pkg::ST_CHAR;
        end
      end
      jti_pkg::ST_PRE_SP: begin
        if (slot_free && cnt_q == SpcW'(1)) state_d = jti_pkg::ST_CHAR;
      end
      jti_pkg::ST_CHAR: begin
        if (slot_free) state_d = post_q ? jti_pkg::ST_POST_NL : job_end_st;
      end
      jti_pkg::ST_POST_NL: begin
        if (slot_free) begin
          state_d = (cnt_q != '0) ? jti_pkg::ST_POST_SP : job_end_st;
        end
      end
      jti_pkg::ST_POST_SP: begin
        if (slot_free && cnt_q == SpcW'(1)) state_d = job_end_st;
      end
      jti_pkg::ST_FINISH: begin
        state_d = jti_pkg::ST_IDLE;
      end
      default: begin
        state_d = jti_pkg::ST_IDLE;
      end
    endcase
  end

  // sequencer outputs: byte offered to the output register
  always_comb begin
    emit      = 1'b0;
    emit_byte = jti_pkg::ChSpace;
    emit_last = 1'b0;
    unique case (state_q)
      jti_pkg::ST_PRE_NL: begin
        emit      = slot_free;
        emit_byte = jti_pkg::ChNl;
      end
      jti_pkg::ST_PRE_SP: begin
        emit      = slot_free;
      end
      jti_pkg::ST_CHAR: begin
        emit      = slot_free;
        emit_byte = job_c_q;
        emit_last = final_job && !post_q;
      end
      jti_pkg::ST_POST_NL: begin
        emit      = slot_free;
        emit_byte = jti_pkg::ChNl;
        emit_last = final_job && (cnt_q == '0);
      end
      jti_pkg::ST_POST_SP: begin
        emit      = slot_free;
        emit_last = final_job && (cnt_q == SpcW'(1));
      end
      default: begin
        emit      = 1'b0;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= jti_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= emit_byte;
      out_last_q <= emit_last;
    end
  end

  // request capture and job loading
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_byte_q <= s_axis_tdata_i;
      in_last_q <= s_axis_tlast_i;
      mode_q    <= fmt_en_q;
    end
    if (state_q == jti_pkg::ST_START) begin
      if (held_valid_q) begin
        job_c_q    <= held_byte_q;
        job_next_q <= in_byte_q;
        job_new_q  <= 1'b0;
      end else begin
        job_c_q    <= in_byte_q;
        job_next_q <= jti_pkg::ChSpace;
        job_new_q  <= 1'b1;
      end
      job_prev_q <= before_q;
    end else if (state_q != jti_pkg::ST_CLASS && state_d == jti_pkg::ST_CLASS) begin
      // second job: the new byte follows the held one
      job_c_q    <= in_byte_q;
      job_prev_q <= held_byte_q;
      job_next_q <= jti_pkg::ChSpace;
      job_new_q  <= 1'b1;
    end
    if (state_q == jti_pkg::ST_CLASS) begin
      post_q <= post_d;
      cnt_q  <= cnt_d;
    end else if (emit && (state_q == jti_pkg::ST_PRE_SP ||
                          state_q == jti_pkg::ST_POST_SP)) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // text state: depths, held byte and the byte before it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_byte_q  <= '0;
      held_valid_q <= 1'b0;
      before_q     <= jti_pkg::ChSpace;
      brace_q      <= '0;
      bracket_q    <= '0;
    end else if (state_q == jti_pkg::ST_CLASS && mode_q) begin
      brace_q   <= brace_d;
      bracket_q <= bracket_d;
    end else if (state_q == jti_pkg::ST_FINISH) begin
      if (!mode_q) begin
        held_byte_q  <= '0;
        held_valid_q <= 1'b0;
        before_q     <= in_last_q ? jti_pkg::ChSpace : in_byte_q;
      end else if (in_last_q) begin
        held_byte_q  <= '0;
        held_valid_q <= 1'b0;
        before_q     <= jti_pkg::ChSpace;
        brace_q      <= '0;
        bracket_q    <= '0;
      end else begin
        if (held_valid_q) before_q <= held_byte_q;
        held_byte_q  <= in_byte_q;
        held_valid_q <= 1'b1;
      end
    end
  end

endmodule

>>> sv/jti_checker.sv
// ----------------------------------------------------------------------------
// jti_checker
// Port-level checks of the JSON text indenter, bound to the top level
// ----------------------------------------------------------------------------
`include "json_text_indenter_assert.svh"

module jti_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid_i,
  input logic       s_axis_tready_o,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o
);

  logic in_acc, out_stall;

  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_stall = m_axis_tvalid_o && !m_axis_tready_i;

  // a stalled result keeps its byte and last flag
  `JTI_ASSERT(a_out_hold, clk_i, rst_ni, out_stall |=> m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))

  // one request at a time: the input closes right after a request is taken
  `JTI_ASSERT(a_busy_after_req, clk_i, rst_ni, in_acc |=> !s_axis_tready_o)

  // reset empties the output register by the next edge
  `JTI_ASSERT_ALWAYS(a_reset_empty, clk_i, !rst_ni |=> !m_axis_tvalid_o)

endmodule

bind json_text_indenter jti_checker u_jti_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o)
);

>>> test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the JSON text indenter: random compact JSON,
// deep nesting and noise bytes are streamed in under both modes, and every
// emitted byte is compared against a cycle-free software indenter
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DepthMax    = 15;
  localparam int unsigned IndentW     = 2;
  localparam int unsigned StepMaxOut  = 64;
  localparam int unsigned PhaseBytes  = 20;
  localparam int unsigned NumPhases   = 6;
  localparam int unsigned DrainCycles = 30;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
  } out_item_t;

  typedef enum int {
    STALL_NONE,
    STALL_RANDOM,
    STALL_SPARSE
  } stall_e;

  // software indenter plus the queue of bytes it still owes
  class indent_scoreboard;
    bit          fmt_en;
    logic [7:0]  held;
    bit          held_vld;
    logic [7:0]  held_prev;
    logic [3:0]  brace_d;
    logic [3:0]  brack_d;
    out_item_t   step_q[$];
    out_item_t   due_q[$];
    int          errors;
    int          n_in;
    int          n_out;

    function new();
      fmt_en    = 1'b1;
      held      = '0;
      held_vld  = 1'b0;
      held_prev = jti_pkg::ChSpace;
      brace_d   = '0;
      brack_d   = '0;
      errors    = 0;
      n_in      = 0;
      n_out     = 0;
    endfunction

    function void set_format(bit en);
      fmt_en = en;
    endfunction

    function int pending();
      return due_q.size();
    endfunction

    function void put_out(logic [7:0] b);
      out_item_t it;
      it.out_byte = b;
      it.run_last = 1'b0;
      if (step_q.size() < StepMaxOut) step_q.push_back(it);
    endfunction

    function void put_indent();
      put_out(jti_pkg::ChNl);
      repeat (int'(brace_d) * IndentW) put_out(jti_pkg::ChSpace);
    endfunction

    // one byte with its neighbors on both sides
    function void format_char(logic [7:0] c, logic [7:0] prev, logic [7:0] nxt);
      if (c == jti_pkg::ChLBrace && brace_d < DepthMax) brace_d++;
      if (c == jti_pkg::ChRBrace && brace_d > 0) brace_d--;
      if (c == jti_pkg::ChLBrack && brack_d < DepthMax) brack_d++;
      if (c == jti_pkg::ChRBrack && brack_d > 0) brack_d--;
      if (c == jti_pkg::ChComma &&
          (brack_d == 0 || (brack_d == 1 && prev == jti_pkg::ChRBrack))) begin
        put_out(c);
        put_indent();
      end else if (c == jti_pkg::ChLBrack && prev == jti_pkg::ChColon &&
                   nxt == jti_pkg::ChLBrack) begin
        put_out(c);
        put_indent();
      end else if (c == jti_pkg::ChLBrace) begin
        put_out(c);
        put_indent();
      end else if (c == jti_pkg::ChRBrace) begin
        put_indent();
        put_out(c);
      end else begin
        put_out(c);
      end
    endfunction

    // accepted request: work out the bytes it releases
    function void take_text_byte(logic [7:0] b, logic last);
      logic [7:0] prev_new;
      step_q.delete();
      if (!fmt_en) begin
        if (held_vld) put_out(held);
        put_out(b);
        held_vld  = 1'b0;
        held      = '0;
        held_prev = last ? jti_pkg::ChSpace : b;
      end else begin
        prev_new = held_prev;
        if (held_vld) begin
          format_char(held, held_prev, b);
          prev_new = held;
        end
        if (last) begin
          format_char(b, prev_new, jti_pkg::ChSpace);
          held_vld  = 1'b0;
          held      = '0;
          held_prev = jti_pkg::ChSpace;
          brace_d   = '0;
          brack_d   = '0;
        end else begin
          held_prev = prev_new;
          held      = b;
          held_vld  = 1'b1;
        end
      end
      if (step_q.size() > 0) step_q[step_q.size()-1].run_last = 1'b1;
      foreach (step_q[i]) due_q.push_back(step_q[i]);
      n_in++;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 30) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_out_byte(logic [7:0] b, logic last);
      out_item_t want;
      n_out++;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected byte %02h last %0b", b, last));
      end else begin
        want = due_q.pop_front();
        if (b !== want.out_byte)
          report($sformatf("out byte %02h, want %02h", b, want.out_byte));
        if (last !== want.run_last)
          report($sformatf("tlast %0b, want %0b (byte %02h)", last, want.run_last, b));
      end
    endtask

    task check_drained();
      if (due_q.size() != 0)
        report($sformatf("%0d bytes never came out", due_q.size()));
    endtask
  endclass

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid   = 1'b0;
  logic [7:0]  s_tdata    = '0;
  logic        s_tlast    = 1'b0;
  logic        m_tready   = 1'b1;
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [2:0]  paddr      = '0;
  logic [31:0] pwdata     = '0;
  wire         s_axis_tready_o;
  wire         m_axis_tvalid_o;
  wire  [7:0]  m_axis_tdata_o;
  wire         m_axis_tlast_o;
  wire  [31:0] prdata_o;
  wire         pready_o;

  indent_scoreboard sb;
  logic [7:0] text_q[$];
  stall_e     stall_mode = STALL_NONE;
  int         gap_max    = 0;
  int         burst_left = 0;
  int         n_sent     = 0;
  int         n_texts    = 0;
  int         n_writes   = 0;
  int         stall_cnt  = 0;

  json_text_indenter #(
    .MAX_DEPTH    (DepthMax),
    .INDENT_WIDTH (IndentW)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),    // [7:0] text_byte
    .s_axis_tlast_i  (s_tlast),    // end_of_text
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [7:0] out_byte
    .m_axis_tlast_o  (m_axis_tlast_o),   // run_last
    .psel_i          (psel),
    .penable_i       (penable),
    .pwrite_i        (pwrite),
    .paddr_i         (paddr),
    .pwdata_i        (pwdata),
    .prdata_o        (prdata_o),
    .pready_o        (pready_o)
  );

  always #5 clk_i = ~clk_i;

  // output side: check accepted bytes, then pick next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_tready)
      sb.check_out_byte(m_axis_tdata_o, m_axis_tlast_o);
    stall_cnt <= stall_cnt + 1;
    case (stall_mode)
      STALL_NONE:   m_tready <= 1'b1;
      STALL_RANDOM: m_tready <= 1'($urandom_range(0, 1));
      default:      m_tready <= (stall_cnt % 5 == 0);
    endcase
  end

  // register write: setup cycle then access cycle
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_format(data[0]);
    n_writes++;
  endtask

  task automatic set_format_mode(input bit en);
    write_reg(3'(jti_pkg::RegFormatEnable * 4), {31'd0, en});
  endtask

  // one request, sent in bursts with random gaps
  task automatic push_byte(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      if (gap_max > 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.take_text_byte(b, last);
    n_sent++;
  endtask

  task automatic send_text(input bit terminate);
    foreach (text_q[i]) push_byte(text_q[i], terminate && (i == text_q.size() - 1));
    if (terminate) n_texts++;
    text_q.delete();
  endtask

  // let the block finish whatever step it is in
  task automatic wait_idle();
    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic void add_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  // quoted string, brackets inside on purpose
  function automatic void gen_string();
    int n;
    string pool;
    pool = "{}[],:ab";
    n = $urandom_range(0, 4);
    text_q.push_back("\"");
    repeat (n) begin
      if ($urandom_range(0, 1)) text_q.push_back(pool[$urandom_range(0, pool.len() - 1)]);
      else text_q.push_back(8'($urandom_range(8'h20, 8'h7E)));
    end
    text_q.push_back("\"");
  endfunction

  function automatic void gen_value(input int lvl);
    int k;
    int n;
    k = (lvl >= 4) ? $urandom_range(2, 4) : $urandom_range(0, 5);
    case (k)
      0: begin
        text_q.push_back(jti_pkg::ChLBrace);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) text_q.push_back(jti_pkg::ChComma);
          gen_string();
          text_q.push_back(jti_pkg::ChColon);
          gen_value(lvl + 1);
        end
        text_q.push_back(jti_pkg::ChRBrace);
      end
      1: begin
        text_q.push_back(jti_pkg::ChLBrack);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) text_q.push_back(jti_pkg::ChComma);
          gen_value(lvl + 1);
        end
        text_q.push_back(jti_pkg::ChRBrack);
      end
      2: gen_string();
      3: repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range("0", "9")));
      4: add_str($urandom_range(0, 1) ? "true" : "null");
      default: begin
        // array of arrays, the shape that breaks after ':['
        text_q.push_back(jti_pkg::ChLBrack);
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) begin
          if (i > 0) text_q.push_back(jti_pkg::ChComma);
          text_q.push_back(jti_pkg::ChLBrack);
          gen_value(4);
          text_q.push_back(jti_pkg::ChRBrack);
        end
        text_q.push_back(jti_pkg::ChRBrack);
      end
    endcase
  endfunction

  // one text: mostly json, some deep nesting, some noise
  function automatic void gen_text();
    int pick;
    int n;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      text_q.push_back(jti_pkg::ChLBrace);
      gen_string();
      text_q.push_back(jti_pkg::ChColon);
      gen_value(1);
      text_q.push_back(jti_pkg::ChRBrace);
      // broken text now and then
      if ($urandom_range(0, 9) == 0)
        repeat ($urandom_range(1, text_q.size() - 1)) void'(text_q.pop_back());
    end else if (pick < 80) begin
      n = $urandom_range(DepthMax - 1, DepthMax + 2);
      repeat (n)
        text_q.push_back($urandom_range(0, 3) == 0 ? jti_pkg::ChLBrack : jti_pkg::ChLBrace);
      add_str("\"a\":1,2");
      repeat (n + 1)
        text_q.push_back($urandom_range(0, 1) ? jti_pkg::ChRBrack : jti_pkg::ChRBrace);
    end else begin
      repeat ($urandom_range(1, 12)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  // main sequence
  initial begin
    int phase_start;
    sb = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_format_mode(1'b1);

    // underflow at depth zero, ':[[' break, commas at bracket depths zero to two
    stall_mode = STALL_RANDOM;
    add_str("}]{a:[[0,5],1,2],b}");
    send_text(1'b1);
    text_q.push_back(8'hFF);
    send_text(1'b1);
    text_q.push_back(8'h00);
    send_text(1'b1);
    s_tvalid <= 1'b0;

    for (int ph = 0; ph < NumPhases; ph++) begin
      wait_idle();
      set_format_mode(ph % 3 != 1);
      stall_mode = stall_e'(ph % 3);
      gap_max    = (ph == 0) ? 0 : ((ph % 2) ? 3 : 8);
      burst_left = 0;
      phase_start = n_sent;
      while (n_sent - phase_start < PhaseBytes) begin
        gen_text();
        send_text($urandom_range(0, 7) != 0);
      end
      // leave a byte held across the mode write when formatting is on
      text_q.push_back($urandom_range(0, 1) ? jti_pkg::ChLBrack : 8'($urandom_range(0, 255)));
      send_text(1'b0);
      s_tvalid <= 1'b0;
    end

    while (sb.pending() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    sb.check_drained();
    $display("covered %0d input bytes in %0d terminated texts, %0d output bytes checked",
             sb.n_in, n_texts, sb.n_out);
    $display("%0d mode writes across formatting and pass-through, %0d mismatches",
             n_writes, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS json_text_indenter");
    end else begin
      $display("FAIL json_text_indenter");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5ms;
    $display("timeout with %0d bytes outstanding", sb.pending());
    $display("FAIL json_text_indenter");
    $finish;
  end

endmodule
